// ----- rtl/core/mf3_pkg.sv -----
`default_nettype none

package mf3_pkg;

    localparam int PIXEL_W      = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;
    localparam int ROW_W        = 12;

    localparam int MAX_HEIGHT    = 4096;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIN_SIZE      = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int QLOAD_W     = QCOUNT_W + 1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd512;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // One classified item: the column of the window it brings in, plus what to do with it.
    typedef struct packed {
        pixel_t up;
        pixel_t lo;
        pixel_t pix;
        logic   emit;
        logic   interior;
        logic   last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic                valid;
        logic [QCOUNT_W-1:0] count;
    } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/mf3_front.sv -----
`default_nettype none

module mf3_front #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [mf3_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               in_fire,
    input  wire mf3_pkg::pixel_t                    in_pixel,
    input  wire logic                               in_drain,
    output mf3_pkg::push_t                          push
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W = (WEFF_W > mf3_pkg::WIDTH_REG_W) ? WEFF_W : mf3_pkg::WIDTH_REG_W;
    localparam int HW     = mf3_pkg::HEIGHT_REG_W;

    localparam logic [WCMP_W-1:0] MAX_W_C = WCMP_W'(MAX_WIDTH);
    localparam logic [HW-1:0]     MAX_H_C = HW'(mf3_pkg::MAX_HEIGHT);

    // Input row count saturates at two: only "none", "one" and "two or more" matter.
    localparam logic [1:0] ROWS_NONE = 2'd0;
    localparam logic [1:0] ROWS_ONE  = 2'd1;
    localparam logic [1:0] ROWS_TWO  = 2'd2;

    logic [mf3_pkg::WIDTH_REG_W-1:0] width_reg;
    logic [HW-1:0]                   height_reg;
    logic [COL_W-1:0]                in_col_reg;
    logic [1:0]                      in_row_reg;
    logic [COL_W-1:0]                out_col_reg;
    logic [mf3_pkg::ROW_W-1:0]       out_row_reg;

    logic [WCMP_W-1:0] w_ext;
    logic [WCMP_W-1:0] w_eff;
    logic [HW-1:0]     h_eff;
    logic [WCMP_W-1:0] in_col_inc;
    logic [WCMP_W-1:0] out_col_inc;
    logic [HW-1:0]     out_row_inc;
    logic              in_wrap;
    logic              out_wrap;
    logic              out_row_end;
    logic              emit;
    logic              interior;
    logic              last;
    mf3_pkg::pixel_t   pix;

    // Line stores and the stage behind them
    mf3_pkg::pixel_t upper_mem [MAX_WIDTH];
    mf3_pkg::pixel_t lower_mem [MAX_WIDTH];

    logic            a_valid_reg;
    logic [COL_W-1:0] a_col_reg;
    mf3_pkg::pixel_t a_pix_reg;
    logic            a_gate_up_reg;
    logic            a_gate_lo_reg;
    logic            a_emit_reg;
    logic            a_interior_reg;
    logic            a_last_reg;
    logic            fwd_reg;
    mf3_pkg::pixel_t fwd_val_reg;
    mf3_pkg::pixel_t up_rd_reg;
    mf3_pkg::pixel_t lo_rd_reg;
    mf3_pkg::pixel_t a_lo;
    mf3_pkg::pixel_t a_up;

    always_comb begin
        w_ext = WCMP_W'(width_reg);
        if (w_ext == '0) begin
            w_eff = WCMP_W'(1);
        end else if (w_ext > MAX_W_C) begin
            w_eff = MAX_W_C;
        end else begin
            w_eff = w_ext;
        end

        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (height_reg > MAX_H_C) begin
            h_eff = MAX_H_C;
        end else begin
            h_eff = height_reg;
        end

        in_col_inc  = WCMP_W'(in_col_reg) + WCMP_W'(1);
        out_col_inc = WCMP_W'(out_col_reg) + WCMP_W'(1);
        out_row_inc = HW'(out_row_reg) + HW'(1);
        in_wrap     = in_col_inc >= w_eff;
        out_wrap    = out_col_inc >= w_eff;
        out_row_end = out_row_inc >= h_eff;

        emit     = (in_row_reg == ROWS_TWO) || ((in_row_reg == ROWS_ONE) && (in_col_reg != '0));
        interior = (out_row_reg != '0) && !out_row_end && (out_col_reg != '0) && !out_wrap;
        last     = out_row_end && out_wrap;
        pix      = in_drain ? '0 : in_pixel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= mf3_pkg::WIDTH_RESET;
            height_reg  <= mf3_pkg::HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= ROWS_NONE;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mf3_pkg::REG_IMAGE_WIDTH: begin
                        width_reg <= cfg_wdata[mf3_pkg::WIDTH_REG_W-1:0];
                    end
                    mf3_pkg::REG_IMAGE_HEIGHT: begin
                        height_reg <= cfg_wdata[HW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                if (emit && last) begin
                    // The last output of the frame restarts every position counter.
                    in_col_reg  <= '0;
                    in_row_reg  <= ROWS_NONE;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else begin
                    if (in_wrap) begin
                        in_col_reg <= '0;
                        case (in_row_reg)
                            ROWS_NONE: begin
                                in_row_reg <= ROWS_ONE;
                            end
                            default: begin
                                in_row_reg <= ROWS_TWO;
                            end
                        endcase
                    end else begin
                        in_col_reg <= in_col_inc[COL_W-1:0];
                    end
                    if (emit) begin
                        if (out_wrap) begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + 1'b1;
                        end else begin
                            out_col_reg <= out_col_inc[COL_W-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_fire;
        end
    end

    assign a_lo = a_gate_lo_reg ? lo_rd_reg : '0;
    assign a_up = a_gate_up_reg ? (fwd_reg ? fwd_val_reg : up_rd_reg) : '0;

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            a_col_reg      <= in_col_reg;
            a_pix_reg      <= pix;
            a_gate_up_reg  <= in_row_reg == ROWS_TWO;
            a_gate_lo_reg  <= in_row_reg != ROWS_NONE;
            a_emit_reg     <= emit;
            a_interior_reg <= interior;
            a_last_reg     <= last;
            // The upper store is written in the next cycle, so a read of the column that the
            // previous item is still writing takes that item's value directly.
            fwd_reg        <= a_valid_reg && (a_col_reg == in_col_reg);
            fwd_val_reg    <= a_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            lower_mem[in_col_reg] <= pix;
            lo_rd_reg             <= lower_mem[in_col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg) begin
            upper_mem[a_col_reg] <= a_lo;
        end
        if (in_fire) begin
            up_rd_reg <= upper_mem[in_col_reg];
        end
    end

    always_comb begin
        push.valid         = a_valid_reg;
        push.item.up       = a_up;
        push.item.lo       = a_lo;
        push.item.pix      = a_pix_reg;
        push.item.emit     = a_emit_reg;
        push.item.interior = a_interior_reg;
        push.item.last     = a_last_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/mf3_queue.sv -----
`default_nettype none

module mf3_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire mf3_pkg::push_t push,
    input  wire logic          pop,
    output mf3_pkg::item_t     head,
    output mf3_pkg::q_status_t status
);

    localparam logic [mf3_pkg::QPTR_W-1:0] LAST_SLOT = mf3_pkg::QPTR_W'(mf3_pkg::QUEUE_DEPTH - 1);

    mf3_pkg::item_t                 slot_reg [mf3_pkg::QUEUE_DEPTH];
    logic [mf3_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [mf3_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [mf3_pkg::QCOUNT_W-1:0]   count_reg;
    logic [mf3_pkg::QCOUNT_W-1:0]   count_next;

    always_comb begin
        case ({push.valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.item;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.valid = count_reg != '0;
    assign status.count = count_reg;

endmodule

`default_nettype wire

// ----- rtl/core/mf3_back.sv -----
`default_nettype none

module mf3_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire mf3_pkg::item_t head,
    input  wire logic           head_valid,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mf3_pkg::pixel_t     out_pixel,
    output logic                out_last
);

    localparam int WIN_IDX_W = $clog2(mf3_pkg::WIN_SIZE);

    typedef logic [WIN_IDX_W-1:0] idx_t;
    typedef logic [mf3_pkg::WIN_SIZE-1:0][mf3_pkg::PIXEL_W-1:0] win_t;

    // Compare and exchange so that the first index holds the smaller value.
    function automatic win_t cmp_swap(input win_t v, input idx_t i, input idx_t j);
        win_t r;
        r = v;
        if (v[i] > v[j]) begin
            r[i] = v[j];
            r[j] = v[i];
        end
        return r;
    endfunction

    logic            en;
    win_t            win_reg;
    win_t            win_next;
    win_t            s1_sorted;
    win_t            s2_sorted;
    win_t            s3_sorted;

    logic            s1_valid_reg;
    win_t            s1_win_reg;
    logic            s1_interior_reg;
    logic            s1_last_reg;
    mf3_pkg::pixel_t s1_center_reg;

    logic            s2_valid_reg;
    win_t            s2_win_reg;
    logic            s2_interior_reg;
    logic            s2_last_reg;
    mf3_pkg::pixel_t s2_center_reg;

    logic            out_valid_reg;
    mf3_pkg::pixel_t out_pixel_reg;
    logic            out_last_reg;

    // The whole pipeline moves when the output register is free or is being emptied.
    assign en  = !out_valid_reg || out_ready;
    assign pop = en && head_valid;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = head.up;
        win_next[5] = head.lo;
        win_next[8] = head.pix;
    end

    // Nine-input median network: sort each row, then pick across rows.
    always_comb begin
        s1_sorted = win_next;
        s1_sorted = cmp_swap(s1_sorted, idx_t'(1), idx_t'(2));
        s1_sorted = cmp_swap(s1_sorted, idx_t'(4), idx_t'(5));
        s1_sorted = cmp_swap(s1_sorted, idx_t'(7), idx_t'(8));
        s1_sorted = cmp_swap(s1_sorted, idx_t'(0), idx_t'(1));
        s1_sorted = cmp_swap(s1_sorted, idx_t'(3), idx_t'(4));
        s1_sorted = cmp_swap(s1_sorted, idx_t'(6), idx_t'(7));
        s1_sorted = cmp_swap(s1_sorted, idx_t'(1), idx_t'(2));
        s1_sorted = cmp_swap(s1_sorted, idx_t'(4), idx_t'(5));
        s1_sorted = cmp_swap(s1_sorted, idx_t'(7), idx_t'(8));
    end

    always_comb begin
        s2_sorted = s1_win_reg;
        s2_sorted = cmp_swap(s2_sorted, idx_t'(0), idx_t'(3));
        s2_sorted = cmp_swap(s2_sorted, idx_t'(5), idx_t'(8));
        s2_sorted = cmp_swap(s2_sorted, idx_t'(4), idx_t'(7));
        s2_sorted = cmp_swap(s2_sorted, idx_t'(3), idx_t'(6));
        s2_sorted = cmp_swap(s2_sorted, idx_t'(1), idx_t'(4));
        s2_sorted = cmp_swap(s2_sorted, idx_t'(2), idx_t'(5));
    end

    always_comb begin
        s3_sorted = s2_win_reg;
        s3_sorted = cmp_swap(s3_sorted, idx_t'(4), idx_t'(7));
        s3_sorted = cmp_swap(s3_sorted, idx_t'(4), idx_t'(2));
        s3_sorted = cmp_swap(s3_sorted, idx_t'(6), idx_t'(4));
        s3_sorted = cmp_swap(s3_sorted, idx_t'(4), idx_t'(2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                win_reg <= win_next;
            end
            if (en) begin
                s1_valid_reg  <= pop && head.emit;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_win_reg      <= s1_sorted;
            s1_interior_reg <= head.interior;
            s1_last_reg     <= head.last;
            s1_center_reg   <= win_next[4];

            s2_win_reg      <= s2_sorted;
            s2_interior_reg <= s1_interior_reg;
            s2_last_reg     <= s1_last_reg;
            s2_center_reg   <= s1_center_reg;

            out_pixel_reg   <= s2_interior_reg ? s3_sorted[4] : s2_center_reg;
            out_last_reg    <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/median_filter_3x3.sv -----
`default_nettype none

// 3x3 median filter over a raster pixel stream. Pixels of one frame enter in raster order on
// the s_ channel (tuser high marks a drain item that carries no pixel) and leave in the same
// order on the m_ channel, image_width + 1 items behind the input, so a frame is flushed with
// that many drain items; tlast marks the last pixel of the frame, which also restarts the
// position counters. Interior pixels become the median of their neighbourhood, pixels in the
// first or last row or column pass unchanged. The block takes one item per clock while its
// queue has room: the line store stage reads and writes each of its two line stores once per
// item, the upper store through a separate read and write port as its write trails its read,
// and the sorting network behind a four-entry queue is pipelined over three register stages.
// image_width (index 0) and image_height (index 1) are written through cfg_; the user must
// write them only while the block is idle, which the block itself does not enforce.
module median_filter_3x3 #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mf3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] pixel_in
    input  wire logic                            s_tuser,   // [0] drain
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // [7:0] pixel_out
    output logic                                 m_tlast
);

    logic                               s_fire;
    logic                               q_pop;
    logic [mf3_pkg::QLOAD_W-1:0]        queue_load;
    mf3_pkg::push_t                     push;
    mf3_pkg::item_t                     q_head;
    mf3_pkg::q_status_t                 q_status;
    mf3_pkg::pixel_t                    out_pixel;

    // Room is counted for the item still in the line store stage as well.
    assign queue_load = mf3_pkg::QLOAD_W'(q_status.count) + mf3_pkg::QLOAD_W'(push.valid);
    assign s_tready   = aresetn && (queue_load < mf3_pkg::QLOAD_W'(mf3_pkg::QUEUE_DEPTH));
    assign s_fire     = s_tvalid && s_tready;

    mf3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_fire   (s_fire),
        .in_pixel  (s_tdata),
        .in_drain  (s_tuser),
        .push      (push)
    );

    mf3_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (q_pop),
        .head    (q_head),
        .status  (q_status)
    );

    mf3_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .head_valid (q_status.valid),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (out_pixel),
        .out_last   (m_tlast)
    );

    assign m_tdata = out_pixel;

    assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (q_status.count < mf3_pkg::QCOUNT_W'(mf3_pkg::QUEUE_DEPTH)))
        else $error("item pushed into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> push.valid)
        else $error("accepted item did not reach the queue");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

endmodule

`default_nettype wire
